FILE: rtl/core/gn3_pkg.sv
// ============================================================================
// gn3_pkg: shared constants and types for the 3D gradient noise block
// Holds opcodes, register indexes, defaults and the table entry type.
// ============================================================================
package gn3_pkg;

    localparam int MAX_PERIOD_DEF      = 256;
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int GRAD_FRAC_BITS_DEF  = 14;

    localparam int COORD_W  = 28;
    localparam int GRAD_W   = 16;
    localparam int NOISE_W  = 18;
    localparam int PERIOD_W = 9;
    localparam int OCT_W    = 3;
    localparam int OP_W     = 2;
    localparam int TIDX_W   = 8;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_EVAL      = 2'd0,
        OP_LOAD_PERM = 2'd1,
        OP_LOAD_GRAD = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD = 1'b0,
        REG_OCTAVE = 1'b1
    } cfg_reg_t;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd4;
    localparam logic [OCT_W-1:0]    OCTAVE_RESET = 3'd0;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gz;
    } grad_t;

endpackage

FILE: rtl/core/gn3_if.sv
// ============================================================================
// gn3_if: request channels of the gradient noise block
// Input item, result item and configuration write channels.
// ============================================================================
interface gn3_in_if;
    import gn3_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [TIDX_W-1:0]          table_index;
    logic [TIDX_W-1:0]          perm_value;
    logic signed [GRAD_W-1:0]   grad_x;
    logic signed [GRAD_W-1:0]   grad_y;
    logic signed [GRAD_W-1:0]   grad_z;
    modport source (output valid, op, coord_x, coord_y, coord_z, table_index,
                    perm_value, grad_x, grad_y, grad_z, input ready);
    modport sink   (input valid, op, coord_x, coord_y, coord_z, table_index,
                    perm_value, grad_x, grad_y, grad_z, output ready);
endinterface

interface gn3_out_if;
    import gn3_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [NOISE_W-1:0]  noise_value;
    logic [7:0]                 texel_byte;
    logic                       is_evaluation;
    modport source (output valid, noise_value, texel_byte, is_evaluation, input ready);
    modport sink   (input valid, noise_value, texel_byte, is_evaluation, output ready);
endinterface

interface gn3_cfg_if;
    import gn3_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [PERIOD_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/gradient_noise_3d.sv
// ============================================================================
// gradient_noise_3d: classic 3D gradient noise evaluator
// Host-loaded permutation and gradient tables, fixed-point point evaluation.
// ============================================================================
// The block takes one request per cycle while the output side does not stall,
// and it returns one result for each request, in the order the requests were
// accepted. Load requests (op 1, 2) write a table entry and return an
// all-zero result; evaluate requests (op 0) walk an elastic pipeline: lattice
// split, two permutation lookups, four more permutation lookups, eight
// gradient lookups, dot products, three levels of lerps, then texel scaling.
// The tables live in synchronous RAMs. The permutation table has one copy for
// the x-corner reads and one per y-corner hash; the gradient table has eight
// copies, one per lattice corner, all written together. A table load travels
// down the pipe and writes each copy at the stage that reads it, so every
// evaluate sees exactly the loads accepted before it, even when a load
// follows right behind. Every pipeline stage advances together; the whole pipe
// stalls only when the output register is full and not taken, so the block
// sustains one request per cycle. Table entries are undefined until loaded.
// Config writes are accepted at any time but must only occur while idle.
module gradient_noise_3d
    import gn3_pkg::*;
#(
    parameter int MAX_PERIOD      = MAX_PERIOD_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int GRAD_FRAC_BITS  = GRAD_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    gn3_in_if.sink    in_req,
    gn3_out_if.source out_res,
    gn3_cfg_if.sink   cfg
);
    localparam int AW = $clog2(MAX_PERIOD);
    localparam int F  = COORD_FRAC_BITS;
    localparam int G  = GRAD_FRAC_BITS;
    localparam int NS = 11;                // pipeline stages ahead of the output
    localparam int IW = COORD_W - F;       // integer part width

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0] period_reg;
    logic [OCT_W-1:0]    octave_reg;
    logic [AW-1:0]       mask;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            octave_reg <= OCTAVE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_PERIOD: period_reg <= cfg.data;
                REG_OCTAVE: octave_reg <= cfg.data[OCT_W-1:0];
                default: ;
            endcase
        end
    end
    logic [PERIOD_W-1:0] period_m1;
    assign period_m1 = period_reg - PERIOD_W'(1);
    generate
        if (AW <= PERIOD_W)
        begin : g_mask_n
            assign mask = period_m1[AW-1:0];
        end
        else
        begin : g_mask_w
            assign mask = AW'(period_m1);
        end
    endgenerate

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together when advance is high
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] ev_reg;
    logic          advance;
    logic          out_vld_reg;

    assign advance      = !out_vld_reg || out_res.ready;
    assign in_req.ready = advance;

    logic acc;
    assign acc = in_req.valid && in_req.ready;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [AW-1:0] tidx;
    assign tidx = AW'(in_req.table_index & TIDX_W'(MAX_PERIOD - 1));
    logic perm_we, grad_we;
    assign perm_we = acc && (op_t'(in_req.op) == OP_LOAD_PERM);
    assign grad_we = acc && (op_t'(in_req.op) == OP_LOAD_GRAD);

    logic [7:0] perm_a_mem [MAX_PERIOD];      // stage-1 reads (x corners)
    logic [7:0] perm_b_mem [4][MAX_PERIOD];   // stage-2 reads, one copy per y corner
    grad_t      grad_mem   [8][MAX_PERIOD];

    // load requests ride the pipe so each copy is written where it is read
    logic          pwe_reg;
    logic [2:0]    gwe_reg;
    logic [7:0]    pdat_reg;
    logic [AW-1:0] widx_reg [3];
    grad_t         gdat_reg [3];
    grad_t         gw;
    assign gw = '{gx: in_req.grad_x, gy: in_req.grad_y, gz: in_req.grad_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ev_reg  <= '0;
            pwe_reg <= 1'b0;
            gwe_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NS-2:0], acc};
            ev_reg  <= {ev_reg[NS-2:0], acc && (op_t'(in_req.op) == OP_EVAL)};
            pwe_reg <= perm_we;
            gwe_reg <= {gwe_reg[1:0], grad_we};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pdat_reg    <= in_req.perm_value;
            widx_reg[0] <= tidx;
            gdat_reg[0] <= gw;
            for (int s = 1; s < 3; s++)
            begin
                widx_reg[s] <= widx_reg[s-1];
                gdat_reg[s] <= gdat_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: split coordinates
    // ------------------------------------------------------------------
    logic [AW-1:0] b0_reg [3];
    logic [AW-1:0] b1_reg [3];
    logic [F-1:0]  r_reg  [5][3];          // fractions ride along
    logic signed [COORD_W-1:0] cin [3];
    assign cin[0] = in_req.coord_x;
    assign cin[1] = in_req.coord_y;
    assign cin[2] = in_req.coord_z;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                b0_reg[k]   <= AW'(cin[k][COORD_W-1:F]) & mask;
                b1_reg[k]   <= AW'(cin[k][COORD_W-1:F] + IW'(1)) & mask;
                r_reg[0][k] <= cin[k][F-1:0];
            end
            for (int s = 1; s < 5; s++)
                r_reg[s] <= r_reg[s-1];
        end
    end

    // Stage 1: read perm[bx0], perm[bx1]; carry y/z lattice
    logic [7:0]    pi_reg, pj_reg;
    logic [AW-1:0] by0_1, by1_1, bz0_1, bz1_1;
    logic [AW-1:0] bz0_2, bz1_2;
    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_a_mem[tidx] <= in_req.perm_value;
        if (advance)
        begin
            pi_reg <= perm_a_mem[b0_reg[0]];
            pj_reg <= perm_a_mem[b1_reg[0]];
            by0_1 <= b0_reg[1]; by1_1 <= b1_reg[1];
            bz0_1 <= b0_reg[2]; bz1_1 <= b1_reg[2];
        end
    end

    // Stage 2: four y-corner hashes
    logic [7:0] h_reg [4];   // b00 b10 b01 b11
    logic [AW-1:0] ha [4];
    assign ha[0] = (AW'(pi_reg) + by0_1) & mask;
    assign ha[1] = (AW'(pj_reg) + by0_1) & mask;
    assign ha[2] = (AW'(pi_reg) + by1_1) & mask;
    assign ha[3] = (AW'(pj_reg) + by1_1) & mask;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (advance && pwe_reg)
                perm_b_mem[k][widx_reg[0]] <= pdat_reg;
            if (advance)
                h_reg[k] <= perm_b_mem[k][ha[k]];
        end
        if (advance)
        begin
            bz0_2 <= bz0_1; bz1_2 <= bz1_1;
        end
    end

    // Stage 3: gradient addresses
    logic [AW-1:0] ga_reg [8];   // corner c: bit0 x, bit1 y, bit2 z
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < 8; c++)
                ga_reg[c] <= (AW'(h_reg[c & 3]) + (c[2] ? bz1_2 : bz0_2)) & mask;
        end
    end

    // Stage 4: gradient reads
    grad_t g_reg [8];
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 8; c++)
        begin
            if (advance && gwe_reg[2])
                grad_mem[c][widx_reg[2]] <= gdat_reg[2];
            if (advance)
                g_reg[c] <= grad_mem[c][ga_reg[c]];
        end
    end

    // Stage 5: products; stage 6: rounded dots
    localparam int RW = F + 2;                 // signed offset width
    localparam int PW = RW + GRAD_W;
    localparam int SW = PW + 2;
    logic signed [PW-1:0] p_reg [8][3];
    logic signed [RW-1:0] roff [8][3];
    always_comb
    begin
        for (int c = 0; c < 8; c++)
            for (int k = 0; k < 3; k++)
                roff[c][k] = c[k] ? ($signed({2'b00, r_reg[4][k]}) - $signed(RW'(1) << F))
                                  : $signed({2'b00, r_reg[4][k]});
    end
    always_ff @(posedge clk)
    begin
        if (advance)
            for (int c = 0; c < 8; c++)
            begin
                p_reg[c][0] <= PW'(roff[c][0]) * PW'(g_reg[c].gx);
                p_reg[c][1] <= PW'(roff[c][1]) * PW'(g_reg[c].gy);
                p_reg[c][2] <= PW'(roff[c][2]) * PW'(g_reg[c].gz);
            end
    end

    localparam int DW = SW - G;
    logic signed [DW-1:0] d_reg [8];
    logic signed [SW-1:0] dsum [8];
    always_comb
    begin
        for (int c = 0; c < 8; c++)
            dsum[c] = SW'(p_reg[c][0]) + SW'(p_reg[c][1]) + SW'(p_reg[c][2])
                      + (SW'(1) <<< (G - 1));
    end
    always_ff @(posedge clk)
    begin
        if (advance)
            for (int c = 0; c < 8; c++)
                d_reg[c] <= DW'(dsum[c] >>> G);
    end

    // s-curves: t2 at stage 5, s at stage 6 (aligned with dots)
    localparam int TW = F + 1;
    logic [2*F-1:0] t2_reg [3];
    logic [F-1:0]   tf_reg [3];
    logic [TW-1:0]  sc_reg [6:8][3];
    logic [3*F+2:0] sprod [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sprod[k] = (3*F+3)'(t2_reg[k][2*F-1:F])
                     * ((3*F+3)'(3) << F) - (3*F+3)'(t2_reg[k][2*F-1:F]) * (3*F+3)'({tf_reg[k], 1'b0});
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t2_reg[k]    <= (2*F)'(r_reg[4][k]) * (2*F)'(r_reg[4][k]);
                tf_reg[k]    <= r_reg[4][k];
                sc_reg[6][k] <= TW'(sprod[k] >> F);
            end
            for (int s = 7; s < 9; s++)
                sc_reg[s] <= sc_reg[s-1];
        end
    end

    // Stages 7..9: x, y, z lerps; diff then multiply per level
    localparam int LW = DW + 2;
    function automatic logic signed [LW-1:0] lerp_f(
        input logic [TW-1:0] s, input logic signed [LW-1:0] a,
        input logic signed [LW-1:0] b);
        logic signed [LW+TW:0] m;
        m = $signed({1'b0, s}) * (LW+TW+1)'(b - a);
        return a + LW'(m >>> F);
    endfunction

    logic signed [LW-1:0] lx_reg [4];
    logic signed [LW-1:0] ly_reg [2];
    logic signed [LW-1:0] lz_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int q = 0; q < 4; q++)
                lx_reg[q] <= lerp_f(sc_reg[6][0], LW'(d_reg[2*q]), LW'(d_reg[2*q+1]));
            for (int q = 0; q < 2; q++)
                ly_reg[q] <= lerp_f(sc_reg[7][1], lx_reg[2*q], lx_reg[2*q+1]);
            lz_reg <= lerp_f(sc_reg[8][2], ly_reg[0], ly_reg[1]);
        end
    end

    // Stage 10: saturate; output register: texel
    localparam logic signed [LW-1:0] NMAX = LW'(131071);
    localparam logic signed [LW-1:0] NMIN = -LW'(131072);
    logic signed [NOISE_W-1:0] n_reg;
    logic signed [NOISE_W-1:0] out_noise_reg;
    logic [7:0]                out_tex_reg;
    logic                      out_ev_reg;
    logic signed [NOISE_W+1:0] tv;
    logic signed [NOISE_W+1:0] tsh;
    assign tv  = (NOISE_W+2)'(n_reg) + ((NOISE_W+2)'(1) <<< F);
    assign tsh = tv >>> (F - 6 + int'(octave_reg));

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n_reg <= (lz_reg > NMAX) ? NOISE_W'(NMAX)
                   : (lz_reg < NMIN) ? NOISE_W'(NMIN) : NOISE_W'(lz_reg);
            out_ev_reg    <= ev_reg[NS-1];
            out_noise_reg <= ev_reg[NS-1] ? n_reg : '0;
            if (!ev_reg[NS-1] || tv < 0)
                out_tex_reg <= '0;
            else
                out_tex_reg <= (tsh > 255) ? 8'd255 : tsh[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= vld_reg[NS-1];
    end

    assign out_res.valid         = out_vld_reg;
    assign out_res.noise_value   = out_noise_reg;
    assign out_res.texel_byte    = out_tex_reg;
    assign out_res.is_evaluation = out_ev_reg;

endmodule

FILE: rtl/core/gn3_checker.sv
// ============================================================================
// gn3_checker: port-level checks for the gradient noise block
// Watches the top level's channels and flags handshake and result slips.
// ============================================================================
module gn3_assertions
    import gn3_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_ev,
    input logic signed [NOISE_W-1:0] out_noise,
    input logic [7:0] out_tex
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_noise) && $stable(out_tex))
        else $error("stalled result changed");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ev |-> out_noise == '0 && out_tex == '0)
        else $error("load result not zero");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input blocked while output empty");
endmodule

bind gradient_noise_3d gn3_assertions u_gn3_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_ev    (out_res.is_evaluation),
    .out_noise (out_res.noise_value),
    .out_tex   (out_res.texel_byte)
);
